// File: rtl/ini_stream_tokenizer_top_defines.svh
// Assertion macros for the configuration text tokenizer.
// Included by the top level; no other dependencies.
`ifndef INI_STREAM_TOKENIZER_TOP_DEFINES_SVH
`define INI_STREAM_TOKENIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked property that is ignored while reset is asserted.
`define IST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property that is checked during reset as well.
`define IST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IST_ASSERT(lbl, clk, rst_n, prop, msg)
`define IST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/ist_pkg.sv
// Shared types and constants of the configuration text tokenizer.
// No dependencies; used by the event output interface, the top level, the reader and the result register.
`timescale 1ns / 1ps

package ist_pkg;

	// Limits of the tokenizer.
	localparam int KEY_MAX_CHARS   = 49;
	localparam int VALUE_MAX_CHARS = 127;
	localparam int MAX_ENTRIES     = 256;

	localparam int CNT_W   = 7;
	localparam int ENTRY_W = 8;

	localparam logic [CNT_W-1:0]   KEY_CAP    = CNT_W'(KEY_MAX_CHARS);
	localparam logic [CNT_W-1:0]   VALUE_CAP  = CNT_W'(VALUE_MAX_CHARS);
	localparam logic [ENTRY_W-1:0] ENTRY_LAST = ENTRY_W'(MAX_ENTRIES - 1);

	// Character codes that steer the reader.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	// Reader states.
	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_COMMENT = 3'd1,
		ST_KEY     = 3'd2,
		ST_VALUE   = 3'd3,
		ST_SECTION = 3'd4
	} reader_state_t;

	// Event codes.
	typedef enum logic [2:0] {
		EV_SECT_CLEAR  = 3'd0,
		EV_SECT_CHAR   = 3'd1,
		EV_KEY_CHAR    = 3'd2,
		EV_KEY_DONE    = 3'd3,
		EV_KEY_ABANDON = 3'd4,
		EV_VALUE_CHAR  = 3'd5,
		EV_ENTRY_DONE  = 3'd6
	} event_kind_t;

	// One result item.
	typedef struct packed {
		event_kind_t        kind;
		logic [ENTRY_W-1:0] entry_number;
		logic [CNT_W-1:0]   char_position;
		logic [7:0]         char_value;
		logic [CNT_W-1:0]   text_length;
	} ist_event_t;

	// Reader status seen by the top level.
	typedef struct packed {
		reader_state_t      state;
		logic [ENTRY_W-1:0] entry_cnt;
	} ist_status_t;

endpackage

// File: rtl/ist_stream_if.sv
// Handshake channels of the tokenizer: text byte input and event output.
// Depends on ist_pkg for field widths.
`timescale 1ns / 1ps

interface ist_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface ist_out_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  event_kind;
	logic [ist_pkg::ENTRY_W-1:0] entry_number;
	logic [ist_pkg::CNT_W-1:0]   char_position;
	logic [7:0]                  char_value;
	logic [ist_pkg::CNT_W-1:0]   text_length;

	modport source(output valid, output event_kind, output entry_number,
		output char_position, output char_value, output text_length, input ready);
	modport sink(input valid, input event_kind, input entry_number,
		input char_position, input char_value, input text_length, output ready);
endinterface

// File: rtl/ini_stream_tokenizer_top.sv
// Channel    Dir  Payload                                     Handshake
// in_ch      in   in_byte                                     valid/ready
// out_ch     out  event_kind, entry_number, char_position,    valid/ready
//                 char_value, text_length
//
// One text byte per cycle is sustained while the output is not stalled; a taken byte passes
// through the input register, then the reader's single state update into the result
// register, where its event is presented. Each byte gives zero or one event.
// Reset clears the reader to idle with zeroed counters; no clearing pass is needed.
// A stalled output holds the event and backs up into the input register only.
// Depends on ist_pkg, the stream interfaces, ist_in_stage, ist_reader, ist_out_stage.
`timescale 1ns / 1ps
`include "ini_stream_tokenizer_top_defines.svh"

module ini_stream_tokenizer_top (
	input  logic      clk,
	input  logic      arst_n,
	ist_in_if.sink    in_ch,
	ist_out_if.source out_ch
);

	logic                 vld_s1;
	logic [7:0]           byte_s1;
	logic                 out_free;
	logic                 step;
	logic                 ev_vld;
	logic                 vld_s2;
	ist_pkg::ist_event_t  ev;
	ist_pkg::ist_status_t sts;

	// The reader steps whenever a byte waits and the result register can take its event.
	assign step = vld_s1 && out_free;

	ist_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.adv     (out_free),
		.vld_s1  (vld_s1),
		.byte_s1 (byte_s1)
	);

	ist_reader u_reader (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.ev_vld  (ev_vld),
		.ev      (ev),
		.sts     (sts)
	);

	ist_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.ev_vld   (ev_vld),
		.ev       (ev),
		.out_free (out_free),
		.vld_s2   (vld_s2),
		.out_ch   (out_ch)
	);

	// An entry done event below saturation advances the entry counter by one.
	`IST_ASSERT(a_entry_step, clk, arst_n, (step && ev_vld && ev.kind == ist_pkg::EV_ENTRY_DONE && sts.entry_cnt != ist_pkg::ENTRY_LAST) |=> (sts.entry_cnt == $past(sts.entry_cnt) + 8'd1), "entry counter did not advance on entry done")
	// The reader state moves only when a byte is stepped.
	`IST_ASSERT(a_state_hold, clk, arst_n, !step |=> $stable(sts.state), "reader state changed without a byte")
	// Input backpressure only comes from a held result.
	`IST_ASSERT_ALWAYS(a_stall_cause, clk, (arst_n && !in_ch.ready) |-> vld_s2, "input stalled with an empty result register")

endmodule

// File: rtl/ist_in_stage.sv
// Input register of the tokenizer: holds one text byte until the reader steps.
// Depends on ist_in_if.
`timescale 1ns / 1ps

module ist_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	ist_in_if.sink        in_ch,
	input  logic          adv,
	output logic          vld_s1,
	output logic [7:0]    byte_s1
);

	logic take;

	// The register takes a new byte when it is empty or being drained.
	assign in_ch.ready = !vld_s1 || adv;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_ch.in_byte;
		end
	end

endmodule

// File: rtl/ist_reader.sv
// Five-state reader: updates the state from one byte and forms its event.
// Depends on ist_pkg.
`timescale 1ns / 1ps

module ist_reader (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           byte_s1,
	output logic                 ev_vld,
	output ist_pkg::ist_event_t  ev,
	output ist_pkg::ist_status_t sts
);

	ist_pkg::reader_state_t           state_q, state_d;
	logic [ist_pkg::CNT_W-1:0]        cnt_q, cnt_d;
	logic [ist_pkg::CNT_W-1:0]        lnb_q, lnb_d;
	logic [ist_pkg::ENTRY_W-1:0]      ent_q, ent_d;
	logic [ist_pkg::CNT_W-1:0]        cnt_inc;
	logic [ist_pkg::ENTRY_W-1:0]      ent_next;

	assign cnt_inc  = cnt_q + 1'b1;
	assign ent_next = (ent_q == ist_pkg::ENTRY_LAST) ? ent_q : ent_q + 1'b1;

	// Next reader state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ist_pkg::ST_COMMENT: begin
				if (byte_s1 == ist_pkg::CH_LF) begin
					state_d = ist_pkg::ST_IDLE;
				end
			end
			ist_pkg::ST_KEY: begin
				if (byte_s1 inside {ist_pkg::CH_NUL, ist_pkg::CH_LF, ist_pkg::CH_CR}) begin
					state_d = ist_pkg::ST_IDLE;
				end else if (byte_s1 == ist_pkg::CH_HASH) begin
					state_d = ist_pkg::ST_COMMENT;
				end else if (byte_s1 == ist_pkg::CH_EQUAL) begin
					state_d = ist_pkg::ST_VALUE;
				end
			end
			ist_pkg::ST_VALUE: begin
				if (byte_s1 inside {ist_pkg::CH_LF, ist_pkg::CH_CR}) begin
					state_d = ist_pkg::ST_IDLE;
				end else if (byte_s1 == ist_pkg::CH_HASH) begin
					state_d = ist_pkg::ST_COMMENT;
				end
			end
			ist_pkg::ST_SECTION: begin
				if (byte_s1 == ist_pkg::CH_LF) begin
					state_d = ist_pkg::ST_IDLE;
				end else if (byte_s1 == ist_pkg::CH_RBRACK) begin
					state_d = ist_pkg::ST_COMMENT;
				end
			end
			default: begin
				// Idle, and any code that is not a state, looks for the next line start.
				if (byte_s1 inside {ist_pkg::CH_NUL, ist_pkg::CH_LF, ist_pkg::CH_CR,
						ist_pkg::CH_SPACE}) begin
					state_d = ist_pkg::ST_IDLE;
				end else if (byte_s1 inside {ist_pkg::CH_HASH, ist_pkg::CH_SEMI}) begin
					state_d = ist_pkg::ST_COMMENT;
				end else if (byte_s1 == ist_pkg::CH_LBRACK) begin
					state_d = ist_pkg::ST_SECTION;
				end else begin
					state_d = ist_pkg::ST_KEY;
				end
			end
		endcase
	end

	// Event and counter updates.
	always_comb begin
		ev_vld           = 1'b0;
		ev.kind          = ist_pkg::EV_SECT_CLEAR;
		ev.entry_number  = ent_q;
		ev.char_position = '0;
		ev.char_value    = '0;
		ev.text_length   = '0;
		cnt_d            = cnt_q;
		lnb_d            = lnb_q;
		ent_d            = ent_q;
		case (state_q)
			ist_pkg::ST_COMMENT: begin
				ev_vld = 1'b0;
			end
			ist_pkg::ST_KEY: begin
				if (byte_s1 inside {ist_pkg::CH_NUL, ist_pkg::CH_LF, ist_pkg::CH_CR,
						ist_pkg::CH_HASH}) begin
					ev_vld  = 1'b1;
					ev.kind = ist_pkg::EV_KEY_ABANDON;
				end else if (byte_s1 inside {ist_pkg::CH_SPACE, ist_pkg::CH_TAB}) begin
					ev_vld = 1'b0;
				end else if (byte_s1 == ist_pkg::CH_EQUAL) begin
					ev_vld         = 1'b1;
					ev.kind        = ist_pkg::EV_KEY_DONE;
					ev.text_length = cnt_q;
					cnt_d          = '0;
					lnb_d          = '0;
				end else if (cnt_q < ist_pkg::KEY_CAP) begin
					ev_vld           = 1'b1;
					ev.kind          = ist_pkg::EV_KEY_CHAR;
					ev.char_position = cnt_q;
					ev.char_value    = byte_s1;
					cnt_d            = cnt_inc;
				end
			end
			ist_pkg::ST_VALUE: begin
				if (byte_s1 == ist_pkg::CH_NUL) begin
					ev_vld = 1'b0;
				end else if (byte_s1 inside {ist_pkg::CH_LF, ist_pkg::CH_CR,
						ist_pkg::CH_HASH}) begin
					// A comment trims trailing blanks; a line end keeps them.
					ev_vld         = 1'b1;
					ev.kind        = ist_pkg::EV_ENTRY_DONE;
					ev.text_length = (byte_s1 == ist_pkg::CH_HASH) ? lnb_q : cnt_q;
					ent_d          = ent_next;
					cnt_d          = '0;
				end else if (byte_s1 == ist_pkg::CH_SPACE && cnt_q == '0) begin
					ev_vld = 1'b0;
				end else if (cnt_q < ist_pkg::VALUE_CAP) begin
					ev_vld           = 1'b1;
					ev.kind          = ist_pkg::EV_VALUE_CHAR;
					ev.char_position = cnt_q;
					ev.char_value    = byte_s1;
					cnt_d            = cnt_inc;
					if (!(byte_s1 inside {ist_pkg::CH_SPACE, ist_pkg::CH_TAB})) begin
						lnb_d = cnt_inc;
					end
				end
			end
			ist_pkg::ST_SECTION: begin
				if (byte_s1 inside {ist_pkg::CH_LF, ist_pkg::CH_RBRACK}) begin
					cnt_d = '0;
				end else if (cnt_q < ist_pkg::KEY_CAP) begin
					ev_vld           = 1'b1;
					ev.kind          = ist_pkg::EV_SECT_CHAR;
					ev.char_position = cnt_q;
					ev.char_value    = byte_s1;
					cnt_d            = cnt_inc;
				end
			end
			default: begin
				if (byte_s1 inside {ist_pkg::CH_NUL, ist_pkg::CH_LF, ist_pkg::CH_CR,
						ist_pkg::CH_SPACE, ist_pkg::CH_HASH, ist_pkg::CH_SEMI}) begin
					ev_vld = 1'b0;
				end else if (byte_s1 == ist_pkg::CH_LBRACK) begin
					ev_vld  = 1'b1;
					ev.kind = ist_pkg::EV_SECT_CLEAR;
					cnt_d   = '0;
				end else begin
					// Any other byte, tab included, opens a key.
					ev_vld        = 1'b1;
					ev.kind       = ist_pkg::EV_KEY_CHAR;
					ev.char_value = byte_s1;
					cnt_d         = ist_pkg::CNT_W'(1);
				end
			end
		endcase
	end

	// Reader registers advance once per stepped byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ist_pkg::ST_IDLE;
			cnt_q   <= '0;
			lnb_q   <= '0;
			ent_q   <= '0;
		end else if (step) begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			lnb_q   <= lnb_d;
			ent_q   <= ent_d;
		end
	end

	assign sts.state     = state_q;
	assign sts.entry_cnt = ent_q;

endmodule

// File: rtl/ist_out_stage.sv
// Result register of the tokenizer: holds one event until the sink takes it.
// Depends on ist_pkg and ist_out_if.
`timescale 1ns / 1ps

module ist_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                ev_vld,
	input  ist_pkg::ist_event_t ev,
	output logic                out_free,
	output logic                vld_s2,
	ist_out_if.source           out_ch
);

	ist_pkg::ist_event_t ev_s2;

	// The register is free when empty or when its transaction completes now.
	assign out_free = !vld_s2 || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_free) begin
			vld_s2 <= step && ev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && ev_vld) begin
			ev_s2 <= ev;
		end
	end

	assign out_ch.valid         = vld_s2;
	assign out_ch.event_kind    = ev_s2.kind;
	assign out_ch.entry_number  = ev_s2.entry_number;
	assign out_ch.char_position = ev_s2.char_position;
	assign out_ch.char_value    = ev_s2.char_value;
	assign out_ch.text_length   = ev_s2.text_length;

endmodule
